/* hdl/assert_macros.svh */
// Assertion macros shared by the lock arbiter RTL.
// Each macro samples on clk and is disabled while rst_n is low.
// Define NO_ASSERTIONS to compile them away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

`define ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, expr, msg)
`define ASSERT_SAME(lbl, ante, cons, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

/* hdl/btla_pkg.sv */
// Package for the bounded ticket lock arbiter: request codes, field widths,
// sequencer states and the scan control word. No dependencies.
package btla_pkg;

  localparam int NUM_THREADS_DEF = 8;

  localparam int REQ_W  = 2;
  localparam int TID_W  = 3;
  localparam int NUMO_W = 4;

  typedef logic [REQ_W-1:0] req_t;

  localparam req_t REQ_TAKE    = 2'd0;
  localparam req_t REQ_QUERY   = 2'd1;
  localparam req_t REQ_RELEASE = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OWN,
    ST_SCAN,
    ST_DRAIN,
    ST_UPDATE
  } seq_state_t;

  typedef struct packed {
    logic clr;
    logic own;
    logic vld;
  } scan_ctl_t;

endpackage

/* hdl/btla_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// Self-contained; used for the per-thread ticket table.
module btla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hdl/btla_scan.sv */
// Scan datapath: captures the requesting thread's entry and folds the ticket
// table, one entry per cycle, into a maximum number and a query block flag.
// Depends on btla_pkg.
module btla_scan
  import btla_pkg::*;
#(
  parameter int NUM_THREADS = NUM_THREADS_DEF
) (
  input  logic                               clk,
  input  scan_ctl_t                          ctl,
  input  logic                               ent_col,
  input  logic [$clog2(NUM_THREADS+1)-1:0]   ent_num,
  input  logic [$clog2(NUM_THREADS)-1:0]     ent_idx,
  input  logic [$clog2(NUM_THREADS)-1:0]     own_idx,
  input  logic                               shared_col,
  output logic                               own_col,
  output logic [$clog2(NUM_THREADS+1)-1:0]   own_num,
  output logic [$clog2(NUM_THREADS+1)-1:0]   max_num,
  output logic                               blocked
);

  localparam int NW = $clog2(NUM_THREADS + 1);

  logic          own_col_r;
  logic [NW-1:0] own_num_r;
  logic [NW-1:0] max_r;
  logic [NW-1:0] max_nxt;
  logic          blk_r;
  logic          blk_nxt;

  // The requester's own old number counts toward the maximum, since a take
  // gives it the shared color before the new number is chosen.
  always_comb begin
    max_nxt = max_r;
    blk_nxt = blk_r;
    if (ctl.clr) begin
      max_nxt = '0;
      blk_nxt = 1'b0;
    end else if (ctl.vld) begin
      if ((ent_col == shared_col || ent_idx == own_idx) && ent_num > max_r) begin
        max_nxt = ent_num;
      end
      if (ent_idx != own_idx && ent_num != '0) begin
        if (ent_col == own_col_r) begin
          if (ent_num < own_num_r || (ent_num == own_num_r && ent_idx < own_idx)) begin
            blk_nxt = 1'b1;
          end
        end else if (own_col_r == shared_col) begin
          blk_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    max_r <= max_nxt;
    blk_r <= blk_nxt;
    if (ctl.own) begin
      own_col_r <= ent_col;
      own_num_r <= ent_num;
    end
  end

  assign own_col = own_col_r;
  assign own_num = own_num_r;
  assign max_num = max_r;
  assign blocked = blk_r;

endmodule

/* hdl/bounded_ticket_lock_arbiter.sv */
// Black-white bakery lock arbiter: one result word for every request word.
// Depends on btla_pkg, btla_ram, btla_scan and assert_macros.svh.
//
// A take in scan mode and a query read the requester's entry and then every
// entry of the ticket RAM, one per cycle, before the drain and update states;
// a take in counter mode, a release or an unused request code reads only the
// requester's entry before the drain and update, and a thread id outside the
// table goes straight to the update state. A new request word is accepted
// only in the idle state. The ticket RAM has a single read port. The result
// register lets a new request word enter while the previous result waits.
// Ticket numbers above 15 are reported in their low four bits.
module bounded_ticket_lock_arbiter
  import btla_pkg::*;
#(
  parameter int NUM_THREADS = NUM_THREADS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_ticket_mode,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [REQ_W-1:0]  in_req_type,
  input  logic [TID_W-1:0]  in_thread_id,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_granted,
  output logic              out_ticket_color,
  output logic [NUMO_W-1:0] out_ticket_number,
  output logic              out_lock_held
);

`include "assert_macros.svh"

  localparam int AW = $clog2(NUM_THREADS);
  localparam int NW = $clog2(NUM_THREADS + 1);
  localparam int EW = NW + 1;
  localparam logic [NW-1:0] NMAX  = NW'(NUM_THREADS);
  localparam logic [NW-1:0] ILAST = NW'(NUM_THREADS - 1);

  seq_state_t state_r, state_nxt;

  logic             mode_r;
  logic             shared_r, shared_nxt;
  logic [NW-1:0]    black_r, black_nxt;
  logic [NW-1:0]    white_r, white_nxt;
  logic             holder_r, holder_nxt;
  req_t             req_r;
  logic [TID_W-1:0] tid_r;
  logic [NW-1:0]    idx_r, idx_nxt;
  logic [NUM_THREADS-1:0] written_r;

  logic          rd_vld_r;
  logic          rd_own_r;
  logic [AW-1:0] rd_idx_r;

  logic          out_valid_r;
  logic          out_granted_r;
  logic          out_col_r;
  logic [NW-1:0] out_num_r;
  logic          out_held_r;

  logic          in_accept;
  logic          out_free;
  logic          in_range;
  logic          need_scan;
  logic [AW-1:0] own_addr;

  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic          ram_we;
  logic [EW-1:0] ram_wdata;
  logic [EW-1:0] ram_rdata;
  logic [EW-1:0] ent;
  logic          upd_go;
  scan_ctl_t     scan_ctl;

  logic          own_col;
  logic [NW-1:0] own_num;
  logic [NW-1:0] max_num;
  logic          blocked;

  logic          wr_en;
  logic          wr_col;
  logic [NW-1:0] wr_num;
  logic [NW-1:0] take_num;
  logic          res_grant;
  logic          res_col;
  logic [NW-1:0] res_num;

  function automatic logic [NW-1:0] sat_inc(input logic [NW-1:0] v);
    return (v >= NMAX) ? NMAX : v + NW'(1);
  endfunction

  assign cfg_ready = 1'b1;
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign in_range  = 32'(tid_r) < 32'(NUM_THREADS);
  assign own_addr  = AW'(tid_r);
  assign need_scan = (req_r == REQ_QUERY) || (req_r == REQ_TAKE && !mode_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = (32'(in_thread_id) < 32'(NUM_THREADS)) ? ST_OWN : ST_UPDATE;
        end
      end
      ST_OWN: begin
        state_nxt = need_scan ? ST_SCAN : ST_DRAIN;
      end
      ST_SCAN: begin
        if (idx_r == ILAST) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall     = 1'b1;
    ram_re       = 1'b0;
    ram_raddr    = own_addr;
    idx_nxt      = idx_r;
    upd_go       = 1'b0;
    scan_ctl.clr = 1'b0;
    scan_ctl.own = rd_vld_r && rd_own_r;
    scan_ctl.vld = rd_vld_r && !rd_own_r;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
      end
      ST_OWN: begin
        ram_re       = 1'b1;
        scan_ctl.clr = 1'b1;
        idx_nxt      = '0;
      end
      ST_SCAN: begin
        ram_re    = 1'b1;
        ram_raddr = idx_r[AW-1:0];
        idx_nxt   = idx_r + NW'(1);
      end
      ST_UPDATE: begin
        upd_go = out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  assign ent = written_r[rd_idx_r] ? ram_rdata : '0;

  btla_ram #(
    .WIDTH (EW),
    .DEPTH (NUM_THREADS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (own_addr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  btla_scan #(
    .NUM_THREADS (NUM_THREADS)
  ) u_scan (
    .clk        (clk),
    .ctl        (scan_ctl),
    .ent_col    (ent[NW]),
    .ent_num    (ent[NW-1:0]),
    .ent_idx    (rd_idx_r),
    .own_idx    (own_addr),
    .shared_col (shared_r),
    .own_col    (own_col),
    .own_num    (own_num),
    .max_num    (max_num),
    .blocked    (blocked)
  );

  assign take_num = mode_r ? sat_inc(shared_r ? white_r : black_r) : sat_inc(max_num);

  always_comb begin
    wr_en      = 1'b0;
    wr_col     = own_col;
    wr_num     = '0;
    shared_nxt = shared_r;
    black_nxt  = black_r;
    white_nxt  = white_r;
    holder_nxt = holder_r;
    res_grant  = 1'b0;
    res_col    = own_col;
    res_num    = own_num;
    if (!in_range) begin
      res_col = 1'b0;
      res_num = '0;
    end else begin
      case (req_r)
        REQ_TAKE: begin
          wr_en   = 1'b1;
          wr_col  = shared_r;
          wr_num  = take_num;
          res_col = shared_r;
          res_num = take_num;
          if (mode_r) begin
            if (shared_r) begin
              white_nxt = take_num;
            end else begin
              black_nxt = take_num;
            end
          end
        end
        REQ_QUERY: begin
          res_grant  = (own_num != '0) && !blocked;
          holder_nxt = holder_r || res_grant;
        end
        REQ_RELEASE: begin
          wr_en      = 1'b1;
          shared_nxt = !own_col;
          holder_nxt = 1'b0;
          res_num    = '0;
          if (mode_r && own_num == NMAX) begin
            if (own_col) begin
              white_nxt = '0;
            end else begin
              black_nxt = '0;
            end
          end
        end
        default: begin
          wr_en = 1'b0;
        end
      endcase
    end
  end

  assign ram_we    = upd_go && wr_en;
  assign ram_wdata = {wr_col, wr_num};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mode_r      <= 1'b0;
      shared_r    <= 1'b0;
      black_r     <= '0;
      white_r     <= '0;
      holder_r    <= 1'b0;
      written_r   <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= ram_re;
      if (cfg_valid && cfg_ready) begin
        mode_r <= cfg_ticket_mode;
      end
      if (upd_go) begin
        shared_r <= shared_nxt;
        black_r  <= black_nxt;
        white_r  <= white_nxt;
        holder_r <= holder_nxt;
      end
      if (ram_we) begin
        written_r[own_addr] <= 1'b1;
      end
      if (upd_go) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    rd_own_r <= (state_r == ST_OWN);
    rd_idx_r <= ram_raddr;
    if (in_accept) begin
      req_r <= in_req_type;
      tid_r <= in_thread_id;
    end
    if (upd_go) begin
      out_granted_r <= res_grant;
      out_col_r     <= res_col;
      out_num_r     <= res_num;
      out_held_r    <= holder_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_granted       = out_granted_r;
  assign out_ticket_color  = out_col_r;
  assign out_ticket_number = NUMO_W'(out_num_r);
  assign out_lock_held     = out_held_r;

  `ASSERT_SAME(a_no_write_during_read, ram_we, !rd_vld_r && !ram_re, "RAM write during read")
  `ASSERT_NEXT(a_update_gives_word, upd_go, out_valid_r, "update gave no result word")
  `ASSERT_SAME(a_grant_holds_lock, out_valid_r && out_granted_r, out_held_r, "grant without lock")
  `ASSERT_ALWAYS(a_scan_in_table, state_r != ST_SCAN || 32'(idx_r) < 32'(NUM_THREADS), "bad index")

endmodule

/* verif/tb.sv */
// Self-checking testbench for bounded_ticket_lock_arbiter: random and directed request words
// checked against a built-in model of the black-white bakery lock in both ticket modes.
// Depends on btla_pkg and the arbiter RTL only.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import btla_pkg::*;

  localparam int NT = NUM_THREADS_DEF;
  localparam req_t REQ_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE = NT + 8;
  localparam int PHASE_WORDS = 130;

  typedef struct packed {
    req_t req;
    logic [TID_W-1:0] tid;
  } lock_word_t;

  typedef struct packed {
    logic granted;
    logic color;
    logic [NUMO_W-1:0] number;
    logic held;
  } lock_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_ticket_mode = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [REQ_W-1:0] in_req_type = '0;
  logic [TID_W-1:0] in_thread_id = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_granted;
  logic out_ticket_color;
  logic [NUMO_W-1:0] out_ticket_number;
  logic out_lock_held;

  bounded_ticket_lock_arbiter i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_ticket_mode   (cfg_ticket_mode),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_req_type       (in_req_type),
    .in_thread_id      (in_thread_id),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_granted       (out_granted),
    .out_ticket_color  (out_ticket_color),
    .out_ticket_number (out_ticket_number),
    .out_lock_held     (out_lock_held)
  );

  always #1 clk = ~clk;

  // Lock state as the arbiter should hold it.
  logic              tcol [NT] = '{default: 1'b0};
  logic [NUMO_W-1:0] tnum [NT] = '{default: '0};
  logic              shared_col = 1'b0;
  logic              held_flag = 1'b0;
  logic              mode_q = 1'b0;
  logic [NUMO_W-1:0] black_cnt = '0;
  logic [NUMO_W-1:0] white_cnt = '0;

  lock_word_t   pend_q [$];
  lock_result_t result_q [$];
  int pushed_cnt = 0;
  int accepted_cnt = 0;
  int mism_cnt = 0;
  int cycle_cnt = 0;
  int gap_left = 0;
  int calm_left = 0;
  int hold_left = 0;
  int open_left = 0;
  lock_word_t   sent_word;
  lock_result_t got_res;
  lock_result_t want_res;

  function automatic logic [NUMO_W-1:0] sat_next(input logic [NUMO_W-1:0] v);
    return (v >= NT) ? NUMO_W'(NT) : v + 1'b1;
  endfunction

  function automatic bit may_enter(input int id);
    logic mc;
    logic [NUMO_W-1:0] mn;
    mc = tcol[id];
    mn = tnum[id];
    if (mn == 0) return 1'b0;
    for (int j = 0; j < NT; j++) begin
      if (j == id || tnum[j] == 0) continue;
      if (tcol[j] == mc) begin
        if (tnum[j] < mn || (tnum[j] == mn && j < id)) return 1'b0;
      end else if (mc == shared_col) begin
        return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function automatic lock_result_t lock_step(input lock_word_t w);
    lock_result_t r;
    int id;
    logic c;
    logic [NUMO_W-1:0] top;
    r = '0;
    id = int'(w.tid);
    case (w.req)
      REQ_TAKE: begin
        c = shared_col;
        tcol[id] = c;
        if (mode_q) begin
          if (c) begin
            white_cnt = sat_next(white_cnt);
            tnum[id] = white_cnt;
          end else begin
            black_cnt = sat_next(black_cnt);
            tnum[id] = black_cnt;
          end
        end else begin
          top = '0;
          for (int i = 0; i < NT; i++)
            if (tcol[i] == c && tnum[i] > top) top = tnum[i];
          tnum[id] = sat_next(top);
        end
      end
      REQ_QUERY: begin
        if (may_enter(id)) begin
          r.granted = 1'b1;
          held_flag = 1'b1;
        end
      end
      REQ_RELEASE: begin
        c = tcol[id];
        shared_col = ~c;
        if (mode_q && tnum[id] == NT) begin
          if (c) white_cnt = '0;
          else black_cnt = '0;
        end
        tnum[id] = '0;
        held_flag = 1'b0;
      end
      default: begin
      end
    endcase
    r.color = tcol[id];
    r.number = tnum[id];
    r.held = held_flag;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic flag_mismatch(input string what, input lock_result_t want,
                               input lock_result_t got);
    mism_cnt++;
    if (mism_cnt <= 10)
      $display("%0t: %s: expected granted=%0d color=%0d number=%0d held=%0d,",
               $realtime, what, want.granted, want.color, want.number, want.held,
               " got granted=%0d color=%0d number=%0d held=%0d",
               got.granted, got.color, got.number, got.held);
  endtask

  // Request driver: one word per accepted handshake, random gaps between words.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        sent_word = '{req: in_req_type, tid: in_thread_id};
        result_q.push_back(lock_step(sent_word));
        accepted_cnt++;
      end
      if (in_valid && in_stall) begin
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pend_q.size() > 0) begin
        sent_word = pend_q.pop_front();
        in_req_type <= sent_word.req;
        in_thread_id <= sent_word.tid;
        in_valid <= 1'b1;
        if (calm_left > 0) begin
          calm_left--;
          gap_left = 0;
        end else begin
          if ($urandom_range(0, 19) == 0) calm_left = $urandom_range(10, 40);
          gap_left = pick_gap();
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result monitor and receiver stall pattern.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      got_res = '{granted: out_granted, color: out_ticket_color,
                  number: out_ticket_number, held: out_lock_held};
      if (result_q.size() == 0) begin
        flag_mismatch("result word with none expected", '0, got_res);
      end else begin
        want_res = result_q.pop_front();
        if (got_res.granted !== want_res.granted || got_res.color !== want_res.color ||
            got_res.number !== want_res.number || got_res.held !== want_res.held)
          flag_mismatch("result word differs", want_res, got_res);
      end
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (open_left > 0) begin
      open_left--;
      out_stall <= 1'b0;
    end else begin
      hold_left = pick_gap();
      open_left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 4);
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic push_word(input req_t r, input int tid);
    pend_q.push_back('{req: r, tid: TID_W'(tid)});
    pushed_cnt++;
  endtask

  task automatic set_mode(input logic m);
    @(posedge clk);
    cfg_ticket_mode <= m;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    mode_q = m;
  endtask

  task automatic wait_idle();
    do @(negedge clk); while (accepted_cnt != pushed_cnt || result_q.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Rounds of takes, queries and releases over random thread sets, mixed with noise words.
  task automatic random_phase(input int n);
    int stop;
    int k;
    int start;
    int j;
    int t;
    int order [NT];
    stop = pushed_cnt + n;
    for (int i = 0; i < NT; i++) order[i] = i;
    while (pushed_cnt < stop) begin
      if ($urandom_range(0, 99) < 15) begin
        push_word(req_t'($urandom_range(0, 3)), $urandom_range(0, NT - 1));
      end else begin
        for (int i = NT - 1; i > 0; i--) begin
          j = $urandom_range(0, i);
          t = order[i];
          order[i] = order[j];
          order[j] = t;
        end
        k = $urandom_range(1, NT);
        for (int i = 0; i < k; i++) begin
          push_word(REQ_TAKE, order[i]);
          if ($urandom_range(0, 3) == 0) push_word(REQ_TAKE, order[i]);
        end
        start = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, k - 1);
        for (int i = 0; i < k; i++) begin
          t = order[(start + i) % k];
          repeat ($urandom_range(0, 2)) push_word(REQ_QUERY, t);
          if ($urandom_range(0, 9) != 0) push_word(REQ_RELEASE, t);
        end
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    set_mode(1'b0);
    push_word(REQ_QUERY, 0);
    push_word(REQ_RELEASE, 5);
    push_word(REQ_UNUSED, 7);
    push_word(REQ_TAKE, 0);
    push_word(REQ_TAKE, 7);
    push_word(REQ_QUERY, 7);
    push_word(REQ_QUERY, 0);
    push_word(REQ_UNUSED, 0);
    push_word(REQ_RELEASE, 0);
    push_word(REQ_TAKE, 2);
    push_word(REQ_QUERY, 2);
    push_word(REQ_QUERY, 7);
    repeat (8) push_word(REQ_TAKE, 4);
    wait_idle();

    set_mode(1'b1);
    repeat (9) push_word(REQ_TAKE, 1);
    push_word(REQ_RELEASE, 1);
    push_word(REQ_TAKE, 6);
    push_word(REQ_RELEASE, 6);
    push_word(REQ_TAKE, 5);
    push_word(REQ_QUERY, 5);
    wait_idle();

    for (int p = 0; p < 6; p++) begin
      set_mode(p[0]);
      random_phase(PHASE_WORDS);
      wait_idle();
    end

    if (mism_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+hdl
hdl/btla_pkg.sv
hdl/btla_ram.sv
hdl/btla_scan.sv
hdl/bounded_ticket_lock_arbiter.sv
verif/tb.sv
